// ===== hw/rtl/utf8dec_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8dec_pkg
// Shared types, constants and helper functions for the UTF-8 to UCS-2
// decoder: field widths, register indexes, sequence offsets, result record.
// ----------------------------------------------------------------------------
package utf8dec_pkg;

	// Field widths.
	localparam int BYTE_W  = 8;
	localparam int UNIT_W  = 16;
	localparam int COUNT_W = 16;
	localparam int LEN_W   = 2;

	// Accumulator width: a lead byte below 0xF8 shifted by three trailing
	// bytes of six bits each fits in 26 bits.
	localparam int ACC_W     = 26;
	localparam int ACC_EXT_W = 32;

	// Configuration port.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_AT_NUL = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHAR_LIMIT  = 1'd1;
	localparam logic [COUNT_W-1:0]   CHAR_LIMIT_RST  = 16'hFFFF;

	// Result queue depth and pointer widths.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Lead byte thresholds and special code units.
	localparam logic [BYTE_W-1:0]    LEAD_2B    = 8'hC0;
	localparam logic [BYTE_W-1:0]    LEAD_3B    = 8'hE0;
	localparam logic [BYTE_W-1:0]    LEAD_4B    = 8'hF0;
	localparam logic [BYTE_W-1:0]    LEAD_BAD   = 8'hF8;
	localparam logic [UNIT_W-1:0]    UNIT_SPACE = 16'h0020;
	localparam logic [ACC_EXT_W-1:0] UNIT_MAX   = 32'h0000FFFF;

	// One result beat.
	typedef struct packed {
		logic [UNIT_W-1:0]  code_unit;
		logic               is_final;
		logic [COUNT_W-1:0] char_count;
	} result_t;

	// Number of trailing bytes announced by a lead byte.
	function automatic logic [LEN_W-1:0] trailing_count(input logic [BYTE_W-1:0] b);
		if (b < LEAD_2B)
			return 2'd0;
		else if (b < LEAD_3B)
			return 2'd1;
		else if (b < LEAD_4B)
			return 2'd2;
		else
			return 2'd3;
	endfunction

	// Sum of the marker bits that the raw accumulation leaves in a sequence.
	function automatic logic [ACC_EXT_W-1:0] seq_offset(input logic [LEN_W-1:0] len);
		logic [ACC_EXT_W-1:0] off;
		case (len)
			2'd1:    off = 32'h00003080;
			2'd2:    off = 32'h000E2080;
			2'd3:    off = 32'h03C82080;
			default: off = 32'h00000000;
		endcase
		return off;
	endfunction

endpackage

// ===== hw/rtl/utf8dec_if.sv =====
// ----------------------------------------------------------------------------
// utf8dec_if
// Valid/ready channels of the decoder: the source byte channel and the
// result channel.
// ----------------------------------------------------------------------------
interface utf8dec_src_if
	import utf8dec_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] source_byte;
	logic              last_byte;

	modport source (output valid, output source_byte, output last_byte, input ready);
	modport sink   (input valid, input source_byte, input last_byte, output ready);
endinterface

interface utf8dec_res_if
	import utf8dec_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [UNIT_W-1:0]  code_unit;
	logic               is_final;
	logic [COUNT_W-1:0] char_count;

	modport source (output valid, output code_unit, output is_final, output char_count,
		input ready);
	modport sink   (input valid, input code_unit, input is_final, input char_count,
		output ready);
endinterface

// ===== hw/rtl/utf8_to_ucs2_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_to_ucs2_decoder
// Decodes a UTF-8 byte stream into 16-bit UCS-2 code units without
// validation, with an end-of-string beat that carries the character count.
// ----------------------------------------------------------------------------
// A result beat is written to the queue at the edge that accepts its byte.
// Throughput: one byte per cycle while source.ready is high, i.e. while the
// four-entry result queue has two free entries; a byte giving a character and
// the final beat adds two; the queue drains one per cycle with result.ready.
// Reset: arst_n clears decode state and the queue at once; stop_at_nul
// resets to 0 and char_limit to 65535.
module utf8_to_ucs2_decoder
	import utf8dec_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	utf8dec_src_if.sink           source,
	utf8dec_res_if.source         result
);

	// Configuration registers.
	logic               stop_at_nul_q;
	logic [COUNT_W-1:0] char_limit_q;

	// Decode state.
	logic [LEN_W-1:0]   pend_q, pend_d;
	logic [LEN_W-1:0]   len_q, len_d;
	logic [ACC_W-1:0]   acc_q, acc_d;
	logic [COUNT_W-1:0] cnt_q, cnt_d;
	logic               fin_q, fin_d;

	// Result queue.
	result_t            q_mem [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]  q_cnt_q;

	// Per-beat decode signals.
	logic                 accept, pop;
	logic                 last;
	logic [BYTE_W-1:0]    b;
	logic                 do_char, do_fin, seq_done;
	logic [UNIT_W-1:0]    char_unit;
	logic [COUNT_W-1:0]   cnt_inc, fin_cnt;
	logic [ACC_W-1:0]     acc_new;
	logic [LEN_W-1:0]     len_new;
	logic [ACC_EXT_W-1:0] diff;
	result_t              char_res, fin_res;
	logic [1:0]           n_push;

	assign accept = source.valid && source.ready;
	assign pop    = result.valid && result.ready;
	assign b      = source.source_byte;
	assign last   = source.last_byte;

	// Accept a byte only while the queue can take two beats.
	assign source.ready = (q_cnt_q <= QCNT_W'(QDEPTH - 2));

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_at_nul_q <= 1'b0;
			char_limit_q  <= CHAR_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STOP_AT_NUL: stop_at_nul_q <= cfg_data[0];
				REG_CHAR_LIMIT:  char_limit_q  <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Decode of one byte: next state and up to two result beats.
	always_comb begin
		pend_d    = pend_q;
		len_d     = len_q;
		acc_d     = acc_q;
		cnt_d     = cnt_q;
		fin_d     = fin_q;
		do_char   = 1'b0;
		do_fin    = 1'b0;
		seq_done  = 1'b0;
		char_unit = UNIT_SPACE;
		acc_new   = acc_q;
		len_new   = len_q;
		cnt_inc   = cnt_q + COUNT_W'(1);
		diff      = '0;

		if (fin_q) begin
			// String already ended: the last byte clears for the next one.
			if (last) begin
				pend_d = '0;
				len_d  = '0;
				acc_d  = '0;
				cnt_d  = '0;
				fin_d  = 1'b0;
			end
		end else begin
			if (pend_q == '0) begin
				if ((cnt_q >= char_limit_q) || (stop_at_nul_q && (b == '0))) begin
					do_fin = 1'b1;
				end else if (b >= LEAD_BAD) begin
					do_char = 1'b1;
				end else begin
					acc_new = ACC_W'(b);
					len_new = trailing_count(b);
					pend_d  = len_new;
					seq_done = (len_new == '0);
					if (!seq_done && last)
						do_fin = 1'b1;
				end
			end else begin
				acc_new  = {acc_q[ACC_W-7:0], 6'b0} + ACC_W'(b);
				pend_d   = pend_q - LEN_W'(1);
				seq_done = (pend_q == LEN_W'(1));
				if (!seq_done && last)
					do_fin = 1'b1;
			end
			acc_d = acc_new;
			len_d = len_new;

			// Completed sequence: remove the marker bits; above 16 bits gives a space.
			if (seq_done) begin
				do_char = 1'b1;
				diff    = ACC_EXT_W'(acc_new) - seq_offset(len_new);
				char_unit = (diff > UNIT_MAX) ? UNIT_SPACE : diff[UNIT_W-1:0];
			end

			// A character counts and may reach the limit or the end.
			if (do_char) begin
				cnt_d  = cnt_inc;
				pend_d = '0;
				if ((cnt_inc >= char_limit_q) || last)
					do_fin = 1'b1;
			end

			if (do_fin) begin
				if (last) begin
					pend_d = '0;
					len_d  = '0;
					acc_d  = '0;
					cnt_d  = '0;
					fin_d  = 1'b0;
				end else begin
					fin_d  = 1'b1;
					pend_d = '0;
				end
			end
		end
	end

	assign fin_cnt = do_char ? cnt_inc : cnt_q;

	assign char_res.code_unit  = char_unit;
	assign char_res.is_final   = 1'b0;
	assign char_res.char_count = '0;
	assign fin_res.code_unit   = '0;
	assign fin_res.is_final    = 1'b1;
	assign fin_res.char_count  = fin_cnt;

	assign n_push = accept ? (2'(do_char) + 2'(do_fin)) : 2'd0;

	// Decode state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			len_q  <= '0;
			acc_q  <= '0;
			cnt_q  <= '0;
			fin_q  <= 1'b0;
		end else if (accept) begin
			pend_q <= pend_d;
			len_q  <= len_d;
			acc_q  <= acc_d;
			cnt_q  <= cnt_d;
			fin_q  <= fin_d;
		end
	end

	// Queue storage: the character beat goes first, the final beat after it.
	always_ff @(posedge clk) begin
		if (accept) begin
			if (do_char) begin
				q_mem[wr_ptr_q] <= char_res;
				if (do_fin)
					q_mem[wr_ptr_q + QPTR_W'(1)] <= fin_res;
			end else if (do_fin) begin
				q_mem[wr_ptr_q] <= fin_res;
			end
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			q_cnt_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(n_push);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			q_cnt_q <= q_cnt_q + QCNT_W'(n_push) - QCNT_W'(pop);
		end
	end

	assign result.valid      = (q_cnt_q != '0);
	assign result.code_unit  = q_mem[rd_ptr_q].code_unit;
	assign result.is_final   = q_mem[rd_ptr_q].is_final;
	assign result.char_count = q_mem[rd_ptr_q].char_count;

`ifndef SYNTHESIS
	// The queue never overfills.
	assert property (@(posedge clk) disable iff (!arst_n) q_cnt_q <= QCNT_W'(QDEPTH))
		else $error("result queue overflow");

	// A finished string never leaves a sequence open.
	assert property (@(posedge clk) disable iff (!arst_n) fin_q |-> (pend_q == '0))
		else $error("pending bytes after end of string");

	// A pop with no push lowers the fill count by one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && (n_push == 2'd0)) |=> (q_cnt_q == $past(q_cnt_q) - QCNT_W'(1)))
		else $error("queue count out of step with pops");

	// A byte of a finished string gives no beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && fin_q) |-> (n_push == 2'd0))
		else $error("beat produced after end of string");
`endif

endmodule

// ===== dv/tb_utf8_to_ucs2_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_to_ucs2_decoder
// Self-checking bench for the UTF-8 to UCS-2 decoder. A queue of source bytes
// is driven through the byte channel with random gaps, and the result channel
// is stalled at random. Every accepted byte runs through a cycle-free model of
// the decoder, and each result beat is checked field by field against the
// oldest predicted beat. The run moves through several register settings,
// the extremes among them.
// ----------------------------------------------------------------------------
module tb_utf8_to_ucs2_decoder;
	import utf8dec_pkg::*;

	// Cycles with no beat on either channel before the run is declared hung.
	localparam int STALL_LIMIT = 4000;

	// Raw marker bits that each sequence length leaves in the sum.
	localparam logic [3:0][31:0] MARK_SUM = {32'h03C82080, 32'h000E2080, 32'h00003080,
		32'h00000000};

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              is_last;
	} src_item_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	utf8dec_src_if src_bus ();
	utf8dec_res_if res_bus ();

	utf8_to_ucs2_decoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.source    (src_bus.sink),
		.result    (res_bus.source)
	);

	src_item_t byte_q[$];
	result_t   decoded_q[$];
	int        queued_bytes;
	int        err_count;
	int        stall_cycles;
	int        src_idle_pct;
	int        res_stall_pct;
	logic      src_took;

	// Decoder model state and its copy of the registers.
	logic [1:0]         ucs_pend;
	logic [1:0]         ucs_len;
	logic [31:0]        ucs_acc;
	logic [COUNT_W-1:0] ucs_count;
	logic               ucs_done;
	logic               cfg_nul;
	logic [COUNT_W-1:0] cfg_limit;

	// Clock with a 2 ns period.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report_error(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		err_count++;
	endtask

	task automatic clear_string();
		ucs_pend = '0;
		ucs_len = '0;
		ucs_acc = '0;
		ucs_count = '0;
		ucs_done = 1'b0;
	endtask

	// Close the string with the count beat; the last byte also rearms the model.
	task automatic end_string(input logic lst);
		decoded_q.push_back(result_t'{'0, 1'b1, ucs_count});
		if (lst) begin
			clear_string();
		end else begin
			ucs_done = 1'b1;
			ucs_pend = '0;
		end
	endtask

	task automatic put_char(input logic [UNIT_W-1:0] unit, input logic lst);
		decoded_q.push_back(result_t'{unit, 1'b0, '0});
		ucs_count = ucs_count + 1'b1;
		ucs_pend = '0;
		if (ucs_count >= cfg_limit || lst)
			end_string(lst);
	endtask

	// Predict the beats caused by one accepted source byte.
	task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic lst);
		logic [31:0] cp;
		if (ucs_done) begin
			if (lst)
				clear_string();
		end else if (ucs_pend == 0 && (ucs_count >= cfg_limit || (cfg_nul && b == 0))) begin
			end_string(lst);
		end else if (ucs_pend == 0 && b >= LEAD_BAD) begin
			put_char(UNIT_SPACE, lst);
		end else begin
			if (ucs_pend == 0) begin
				ucs_acc = {24'd0, b};
				if (b < LEAD_2B)
					ucs_len = 2'd0;
				else if (b < LEAD_3B)
					ucs_len = 2'd1;
				else if (b < LEAD_4B)
					ucs_len = 2'd2;
				else
					ucs_len = 2'd3;
				ucs_pend = ucs_len;
			end else begin
				ucs_acc = (ucs_acc << 6) + {24'd0, b};
				ucs_pend = ucs_pend - 1'b1;
			end
			if (ucs_pend == 0) begin
				cp = ucs_acc - MARK_SUM[ucs_len];
				put_char((cp > UNIT_MAX) ? UNIT_SPACE : cp[UNIT_W-1:0], lst);
			end else if (lst) begin
				end_string(1'b1);
			end
		end
	endtask

	task automatic check_result();
		result_t want;
		if (decoded_q.size() == 0) begin
			report_error($sformatf("unexpected beat: unit %h final %b count %0d",
				res_bus.code_unit, res_bus.is_final, res_bus.char_count));
		end else begin
			want = decoded_q.pop_front();
			if (res_bus.code_unit !== want.code_unit)
				report_error($sformatf("code_unit %h, expected %h",
					res_bus.code_unit, want.code_unit));
			if (res_bus.is_final !== want.is_final)
				report_error($sformatf("is_final %b, expected %b",
					res_bus.is_final, want.is_final));
			if (res_bus.char_count !== want.char_count)
				report_error($sformatf("char_count %0d, expected %0d",
					res_bus.char_count, want.char_count));
		end
	endtask

	// Monitor: predict on every accepted byte and check every result beat.
	always @(posedge clk) begin
		src_took <= arst_n && src_bus.valid && src_bus.ready;
		if (arst_n && src_bus.valid && src_bus.ready)
			decode_byte(src_bus.source_byte, src_bus.last_byte);
		if (arst_n && res_bus.valid && res_bus.ready)
			check_result();
	end

	// Driver: offer the next byte once the current one is taken, with gaps.
	always @(negedge clk) begin
		res_bus.ready <= ($urandom_range(99) >= res_stall_pct);
		if (arst_n && (!src_bus.valid || src_took)) begin
			if (byte_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
				src_bus.valid <= 1'b1;
				src_bus.source_byte <= byte_q[0].data;
				src_bus.last_byte <= byte_q[0].is_last;
				void'(byte_q.pop_front());
			end else begin
				src_bus.valid <= 1'b0;
			end
		end
	end

	// Watchdog on cycles without any beat.
	always @(posedge clk) begin
		if (!arst_n || (src_bus.valid && src_bus.ready) || (res_bus.valid && res_bus.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_utf8_to_ucs2_decoder: errors");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic push_byte(input logic [BYTE_W-1:0] b, input logic lst);
		byte_q.push_back(src_item_t'{b, lst});
		queued_bytes++;
	endtask

	// Wait until every byte is taken and every predicted beat has arrived,
	// then give an ignored trailing byte time to settle inside the block.
	task automatic wait_idle();
		while (byte_q.size() != 0 || src_bus.valid || decoded_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input logic nul, input logic [COUNT_W-1:0] lim);
		write_reg(REG_STOP_AT_NUL, CFG_DATA_W'(nul));
		write_reg(REG_CHAR_LIMIT, lim);
		cfg_nul = nul;
		cfg_limit = lim;
	endtask

	task automatic add_lead(ref src_item_t str[$], input int ntrail);
		logic [BYTE_W-1:0] b;
		case (ntrail)
			1:       b = LEAD_2B | BYTE_W'($urandom_range(31));
			2:       b = LEAD_3B | BYTE_W'($urandom_range(15));
			default: b = LEAD_4B | BYTE_W'($urandom_range(7));
		endcase
		str.push_back(src_item_t'{b, 1'b0});
	endtask

	task automatic add_cont(ref src_item_t str[$], input int n);
		for (int i = 0; i < n; i++)
			str.push_back(src_item_t'{8'h80 | BYTE_W'($urandom_range(63)), 1'b0});
	endtask

	// Strings of mostly well-formed characters with random payload, some noise,
	// zero bytes, bad leads and strings cut off inside a sequence.
	task automatic queue_random_strings(input int n_bytes, input int max_chars);
		src_item_t str[$];
		int        start;
		int        r;
		int        t;
		start = queued_bytes;
		while (queued_bytes - start < n_bytes) begin
			str.delete();
			repeat ($urandom_range(1, max_chars)) begin
				r = $urandom_range(99);
				if (r < 45) begin
					str.push_back(src_item_t'{BYTE_W'($urandom_range(1, 127)), 1'b0});
				end else if (r < 88) begin
					t = (r < 65) ? 1 : (r < 80) ? 2 : 3;
					add_lead(str, t);
					add_cont(str, t);
				end else if (r < 92) begin
					str.push_back(src_item_t'{8'h00, 1'b0});
				end else if (r < 95) begin
					str.push_back(src_item_t'{BYTE_W'($urandom_range(8'hF8, 8'hFF)), 1'b0});
				end else begin
					str.push_back(src_item_t'{BYTE_W'($urandom_range(255)), 1'b0});
				end
			end
			if ($urandom_range(99) < 15) begin
				t = $urandom_range(1, 3);
				add_lead(str, t);
				add_cont(str, $urandom_range(0, t - 1));
			end
			str[str.size() - 1].is_last = 1'b1;
			foreach (str[i])
				push_byte(str[i].data, str[i].is_last);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		src_bus.valid = 1'b0;
		src_bus.source_byte = '0;
		src_bus.last_byte = 1'b0;
		res_bus.ready = 1'b0;
		src_took = 1'b0;
		err_count = 0;
		stall_cycles = 0;
		queued_bytes = 0;
		cfg_nul = 1'b0;
		cfg_limit = CHAR_LIMIT_RST;
		clear_string();
		src_idle_pct = 14;
		res_stall_pct = 88;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: ASCII, a zero byte as plain data, every sequence
		// length, a code point above 0xFFFF, bad leads, a stray continuation
		// byte as lead, the largest code unit, then a cut-off sequence.
		push_byte(8'h41, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hC2, 1'b0);
		push_byte(8'hA9, 1'b0);
		push_byte(8'hE2, 1'b0);
		push_byte(8'h82, 1'b0);
		push_byte(8'hAC, 1'b0);
		push_byte(8'hF0, 1'b0);
		push_byte(8'h9F, 1'b0);
		push_byte(8'h98, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'hF8, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'hEF, 1'b0);
		push_byte(8'hBF, 1'b0);
		push_byte(8'hBF, 1'b0);
		push_byte(8'hE2, 1'b0);
		push_byte(8'h82, 1'b1);
		// A character on the last byte gives the character and the count beat.
		push_byte(8'h5A, 1'b1);
		wait_idle();

		// NUL mode with a limit of two: a zero trailing byte is data, a zero
		// lead ends the string, and reaching the limit ends the next one.
		set_config(1'b1, 16'd2);
		push_byte(8'hC2, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h42, 1'b1);
		push_byte(8'h41, 1'b0);
		push_byte(8'h42, 1'b0);
		push_byte(8'h43, 1'b1);
		wait_idle();

		// A limit of zero ends every string at its first byte.
		set_config(1'b0, 16'd0);
		push_byte(8'h41, 1'b1);
		wait_idle();

		// Random part, first with a slow receiver.
		set_config(1'b0, 16'hFFFF);
		queue_random_strings(250, 12);
		wait_idle();
		set_config(1'b1, 16'd3);
		queue_random_strings(200, 8);
		wait_idle();

		// Slow sender from here on.
		src_idle_pct = 88;
		res_stall_pct = 14;
		set_config(1'b1, 16'hFFFF);
		queue_random_strings(200, 12);
		wait_idle();
		set_config(1'b0, 16'd1);
		queue_random_strings(100, 6);
		wait_idle();

		// Full rate on both sides.
		src_idle_pct = 0;
		res_stall_pct = 0;
		set_config(1'b0, 16'd0);
		queue_random_strings(50, 4);
		wait_idle();
		set_config(1'b1, 16'($urandom_range(2, 20)));
		queue_random_strings(150, 16);
		wait_idle();
		repeat (8) @(posedge clk);

		if (err_count == 0 && decoded_q.size() == 0) begin
			$display("tb_utf8_to_ucs2_decoder: clean");
		end else begin
			$display("tb_utf8_to_ucs2_decoder: errors");
		end
		$finish;
	end

endmodule
